>>> design/ttf_pkg.sv
// ttf_pkg: shared constants and helpers for the triangle tangent frame block.
// No dependencies; used by ttf_back, the top level and the testbench.
package ttf_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int NORMAL_WIDTH_DEF = 16;
	localparam int TRI_QUEUE_DEPTH  = 2;
	localparam int RES_QUEUE_DEPTH  = 2;

	localparam int ACC_W      = 64;
	localparam int DELTA_BITS = 31;
	localparam int U_BITS     = 30;

	function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
		abs_acc = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
	endfunction

	function automatic logic signed [ACC_W-1:0] apply_sign(input logic [ACC_W-1:0] m,
		input logic n);
		apply_sign = n ? $signed(~m + ACC_W'(1)) : $signed(m);
	endfunction

endpackage

>>> design/ttf_fifo.sv
// ttf_fifo: small register queue, first word fall through.
// Depends on nothing; used between front and back and on the result side.
module ttf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] data_in,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] data_out,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> design/ttf_front.sv
// ttf_front: takes corners, holds the first two, forms deltas on the third.
// Depends on nothing; feeds the triangle queue read by ttf_back.
module ttf_front #(
	parameter int COORD_WIDTH  = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [COORD_WIDTH-1:0]  pos_x,
	input  logic signed [COORD_WIDTH-1:0]  pos_y,
	input  logic signed [COORD_WIDTH-1:0]  pos_z,
	input  logic signed [COORD_WIDTH-1:0]  tex_s,
	input  logic signed [COORD_WIDTH-1:0]  tex_t,
	input  logic signed [NORMAL_WIDTH-1:0] norm_x,
	input  logic signed [NORMAL_WIDTH-1:0] norm_y,
	input  logic signed [NORMAL_WIDTH-1:0] norm_z,
	output logic                           tq_push,
	output logic [10*(COORD_WIDTH+1)+9*NORMAL_WIDTH-1:0] tq_data,
	input  logic                           tq_full
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int NW = NORMAL_WIDTH;

	logic [1:0]             cnt_q;
	logic [COORD_WIDTH-1:0] hp_q [2][3];
	logic [COORD_WIDTH-1:0] ht_q [2][2];
	logic [NW-1:0]          hn_q [2][3];
	logic [COORD_WIDTH-1:0] p_in [3];
	logic [COORD_WIDTH-1:0] t_in [2];
	logic [NW-1:0]          n_in [3];
	logic                   acc;

	function automatic logic [EW-1:0] sub_ext(input logic [COORD_WIDTH-1:0] a,
		input logic [COORD_WIDTH-1:0] b);
		sub_ext = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
	endfunction

	assign p_in = '{pos_x, pos_y, pos_z};
	assign t_in = '{tex_s, tex_t};
	assign n_in = '{norm_x, norm_y, norm_z};

	assign full    = cnt_q[1] && tq_full;
	assign acc     = push && !full;
	assign tq_push = acc && cnt_q[1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tq_data[i*EW +: EW]     = sub_ext(hp_q[1][i], hp_q[0][i]);
			tq_data[(3+i)*EW +: EW] = sub_ext(p_in[i], hp_q[0][i]);
			tq_data[10*EW + i*NW +: NW]     = hn_q[0][i];
			tq_data[10*EW + (3+i)*NW +: NW] = hn_q[1][i];
			tq_data[10*EW + (6+i)*NW +: NW] = n_in[i];
		end
		tq_data[6*EW +: EW] = sub_ext(ht_q[1][0], ht_q[0][0]);
		tq_data[7*EW +: EW] = sub_ext(ht_q[1][1], ht_q[0][1]);
		tq_data[8*EW +: EW] = sub_ext(t_in[0], ht_q[0][0]);
		tq_data[9*EW +: EW] = sub_ext(t_in[1], ht_q[0][1]);
	end

	always_ff @(posedge clk) begin
		if (acc && !cnt_q[1]) begin
			for (int i = 0; i < 3; i++) begin
				hp_q[cnt_q[0]][i] <= p_in[i];
				hn_q[cnt_q[0]][i] <= n_in[i];
			end
			ht_q[cnt_q[0]][0] <= t_in[0];
			ht_q[cnt_q[0]][1] <= t_in[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= cnt_q[1] ? 2'd0 : cnt_q + 2'd1;
		end
	end

endmodule

>>> design/ttf_back.sv
// ttf_back: per-triangle directions and per-corner tangent on shared units.
// Depends on ttf_pkg; reads the triangle queue, writes the result queue.
module ttf_back #(
	parameter int COORD_WIDTH  = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [10*(COORD_WIDTH+1)+9*NORMAL_WIDTH-1:0] tq_data,
	input  logic tq_empty,
	output logic tq_pop,
	output logic rq_push,
	output logic [3*NORMAL_WIDTH+2:0] rq_data,
	input  logic rq_full
);
	import ttf_pkg::*;

	localparam int EW  = COORD_WIDTH + 1;
	localparam int NW  = NORMAL_WIDTH;
	localparam int F   = NW - 2;
	localparam int SB  = 60 - 2 * NW;
	localparam int BW  = SB + 1;
	localparam int XW  = 62 - NW;
	localparam int DW  = 63 - NW;
	localparam int JW  = $clog2(F + 1);
	localparam int RBW = 7;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_RED   = 17'b00000000000000010,
		S_DP    = 17'b00000000000000100,
		S_DT    = 17'b00000000000001000,
		S_MUL   = 17'b00000000000010000,
		S_SUB   = 17'b00000000000100000,
		S_ADONE = 17'b00000000001000000,
		S_CDONE = 17'b00000000010000000,
		S_CN1   = 17'b00000000100000000,
		S_CN2   = 17'b00000001000000000,
		S_CN3   = 17'b00000010000000000,
		S_CN4   = 17'b00000100000000000,
		S_UDONE = 17'b00001000000000000,
		S_SQ    = 17'b00010000000000000,
		S_SQRT  = 17'b00100000000000000,
		S_DIV   = 17'b01000000000000000,
		S_EMIT  = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d, rret_q, rret_d;
	logic [1:0] k_q, k_d;

	logic [ACC_W-1:0]        mag_q [6];
	logic                    neg_q [6];
	logic [RBW-1:0]          rbits_q;
	logic signed [31:0]      dp_q [6];
	logic signed [31:0]      dt_q [4];
	logic signed [NW-1:0]    nrm_q [9];
	logic signed [ACC_W-1:0] pd0_q, pd1_q;
	logic signed [ACC_W-1:0] pa0_q [3], pa1_q [3], pc0_q [3], pc1_q [3];
	logic signed [ACC_W-1:0] c_q [3];
	logic                    det_zero_q, det_neg_q;
	logic signed [BW-1:0]    b_q [3], bt_q [3];
	logic signed [NW:0]      cr_q [3];
	logic signed [XW-1:0]    nb_q [3], x_q [6], xc_q [3];
	logic signed [DW-1:0]    d_q;
	logic signed [ACC_W-1:0] nd_q [3], tp_q [3];
	logic [59:0]             sq_q [3];
	logic [ACC_W-1:0]        rem_q, res_q, bit_q, dsh_q;
	logic [31:0]             len_q;
	logic [F:0]              q_q;
	logic [JW-1:0]           dj_q;
	logic [1:0]              ci_q;
	logic [NW-1:0]           tan_q [3];
	logic                    hand_q, deg_q;

	logic [ACC_W-1:0]        or_v, sq_trial, mag_next, rem_sub;
	logic                    hi8, hi1, div_ge;
	logic [F:0]              qf;
	logic signed [ACC_W-1:0] a_v [3], tsum;

	function automatic logic signed [ACC_W-1:0] rec_field(
		input logic [10*(COORD_WIDTH+1)+9*NORMAL_WIDTH-1:0] r, input int idx);
		logic [EW-1:0] f;
		f = r[idx*EW +: EW];
		rec_field = $signed({{(ACC_W-EW){f[EW-1]}}, f});
	endfunction

	always_comb begin
		or_v = '0;
		for (int i = 0; i < 6; i++) begin
			or_v = or_v | mag_q[i];
		end
		hi8 = (or_v >> (rbits_q + RBW'(8))) != '0;
		hi1 = (or_v >> rbits_q) != '0;
		sq_trial = res_q + bit_q;
		div_ge   = rem_q >= dsh_q;
		rem_sub  = rem_q - dsh_q;
		qf = q_q;
		qf[dj_q] = div_ge;
		mag_next = mag_q[3'(ci_q) + 3'd1];
		for (int i = 0; i < 3; i++) begin
			a_v[i] = pa0_q[i] - pa1_q[i];
		end
		tsum = tp_q[0] + tp_q[1] + tp_q[2];
	end

	// triangle stays at the queue head until its texture deltas are loaded
	assign tq_pop  = (state_q == S_DP);
	assign rq_push = (state_q == S_EMIT) && !rq_full;
	assign rq_data = {tan_q[0], tan_q[1], tan_q[2], hand_q, deg_q, (k_q == 2'd2)};

	always_comb begin
		state_d = state_q;
		rret_d  = rret_q;
		k_d     = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (!tq_empty) begin
					state_d = S_RED;
					rret_d  = S_DP;
				end
			end
			S_RED:   if (!hi1) state_d = rret_q;
			S_DP: begin
				state_d = S_RED;
				rret_d  = S_DT;
			end
			S_DT:    state_d = S_MUL;
			S_MUL:   state_d = S_SUB;
			S_SUB: begin
				state_d = S_RED;
				rret_d  = S_ADONE;
			end
			S_ADONE: begin
				state_d = S_RED;
				rret_d  = S_CDONE;
			end
			S_CDONE: begin
				k_d     = 2'd0;
				state_d = det_zero_q ? S_EMIT : S_CN1;
			end
			S_CN1:   state_d = S_CN2;
			S_CN2:   state_d = S_CN3;
			S_CN3:   state_d = S_CN4;
			S_CN4: begin
				state_d = S_RED;
				rret_d  = S_UDONE;
			end
			S_UDONE: state_d = S_SQ;
			S_SQ:    state_d = S_SQRT;
			S_SQRT: begin
				if (bit_q == '0) begin
					state_d = (res_q == '0) ? S_EMIT : S_DIV;
				end
			end
			S_DIV: begin
				if (dj_q == '0 && ci_q == 2'd2) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!rq_full) begin
					if (k_q == 2'd2) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + 2'd1;
						state_d = det_zero_q ? S_EMIT : S_CN1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rret_q  <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			rret_q  <= rret_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int i = 0; i < 6; i++) begin
					mag_q[i] <= abs_acc(rec_field(tq_data, i));
					neg_q[i] <= rec_field(tq_data, i) < 0;
				end
				for (int j = 0; j < 9; j++) begin
					nrm_q[j] <= $signed(tq_data[10*EW + j*NW +: NW]);
				end
				rbits_q <= RBW'(DELTA_BITS);
			end
			S_RED: begin
				for (int i = 0; i < 6; i++) begin
					if (hi8) begin
						mag_q[i] <= mag_q[i] >> 8;
					end else if (hi1) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			S_DP: begin
				for (int i = 0; i < 6; i++) begin
					dp_q[i] <= 32'(apply_sign(mag_q[i], neg_q[i]));
				end
				for (int i = 0; i < 4; i++) begin
					mag_q[i] <= abs_acc(rec_field(tq_data, 6 + i));
					neg_q[i] <= rec_field(tq_data, 6 + i) < 0;
				end
				mag_q[4] <= '0;
				mag_q[5] <= '0;
				neg_q[4] <= 1'b0;
				neg_q[5] <= 1'b0;
			end
			S_DT: begin
				for (int i = 0; i < 4; i++) begin
					dt_q[i] <= 32'(apply_sign(mag_q[i], neg_q[i]));
				end
			end
			S_MUL: begin
				pd0_q <= dt_q[0] * dt_q[3];
				pd1_q <= dt_q[2] * dt_q[1];
				for (int i = 0; i < 3; i++) begin
					pa0_q[i] <= dt_q[3] * dp_q[i];
					pa1_q[i] <= dt_q[1] * dp_q[3+i];
					pc0_q[i] <= dt_q[0] * dp_q[3+i];
					pc1_q[i] <= dt_q[2] * dp_q[i];
				end
			end
			S_SUB: begin
				det_zero_q <= (pd0_q == pd1_q);
				det_neg_q  <= (pd0_q < pd1_q);
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= abs_acc(a_v[i]);
					neg_q[i] <= a_v[i][ACC_W-1];
					c_q[i]   <= pc0_q[i] - pc1_q[i];
				end
				mag_q[3] <= '0;
				neg_q[3] <= 1'b0;
				rbits_q  <= RBW'(SB);
			end
			S_ADONE: begin
				for (int i = 0; i < 3; i++) begin
					b_q[i]   <= BW'(apply_sign(mag_q[i], neg_q[i]));
					bt_q[i]  <= BW'(apply_sign(mag_q[i], neg_q[i] ^ det_neg_q));
					mag_q[i] <= abs_acc(c_q[i]);
					neg_q[i] <= c_q[i][ACC_W-1];
				end
				rbits_q <= RBW'(NW);
			end
			S_CDONE: begin
				for (int i = 0; i < 3; i++) begin
					cr_q[i]  <= (NW+1)'(apply_sign(mag_q[i], neg_q[i]));
					tan_q[i] <= '0;
				end
				hand_q <= 1'b0;
				deg_q  <= det_zero_q;
			end
			S_CN1: begin
				for (int i = 0; i < 3; i++) begin
					nb_q[i] <= nrm_q[i] * bt_q[i];
				end
				x_q[0] <= nrm_q[1] * b_q[2];
				x_q[1] <= nrm_q[2] * b_q[1];
				x_q[2] <= nrm_q[2] * b_q[0];
				x_q[3] <= nrm_q[0] * b_q[2];
				x_q[4] <= nrm_q[0] * b_q[1];
				x_q[5] <= nrm_q[1] * b_q[0];
			end
			S_CN2: begin
				d_q <= DW'(nb_q[0]) + DW'(nb_q[1]) + DW'(nb_q[2]);
				for (int i = 0; i < 3; i++) begin
					xc_q[i] <= x_q[2*i] - x_q[2*i+1];
				end
			end
			S_CN3: begin
				for (int i = 0; i < 3; i++) begin
					nd_q[i] <= nrm_q[i] * d_q;
					tp_q[i] <= xc_q[i] * cr_q[i];
				end
			end
			S_CN4: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= abs_acc((ACC_W'(bt_q[i]) <<< (2*F)) - nd_q[i]);
					neg_q[i] <= ((ACC_W'(bt_q[i]) <<< (2*F)) - nd_q[i]) < 0;
				end
				hand_q  <= tsum[ACC_W-1];
				rbits_q <= RBW'(U_BITS);
			end
			S_UDONE: begin
				for (int i = 0; i < 3; i++) begin
					sq_q[i] <= mag_q[i][U_BITS-1:0] * mag_q[i][U_BITS-1:0];
				end
			end
			S_SQ: begin
				rem_q <= ACC_W'(sq_q[0]) + ACC_W'(sq_q[1]) + ACC_W'(sq_q[2]);
				res_q <= '0;
				bit_q <= ACC_W'(1) << 62;
			end
			S_SQRT: begin
				if (bit_q != '0) begin
					if (rem_q >= sq_trial) begin
						rem_q <= rem_q - sq_trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (res_q == '0) begin
					deg_q  <= 1'b1;
					hand_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						tan_q[i] <= '0;
					end
				end else begin
					len_q <= res_q[31:0];
					rem_q <= (mag_q[0] << (F + 1)) + ACC_W'(res_q[31:0]);
					dsh_q <= ACC_W'(res_q[31:0]) << (F + 1);
					q_q   <= '0;
					dj_q  <= JW'(F);
					ci_q  <= 2'd0;
				end
			end
			S_DIV: begin
				if (dj_q == '0) begin
					tan_q[ci_q] <= neg_q[ci_q] ? NW'(~{1'b0, qf} + 1'b1) : NW'(qf);
					if (ci_q == 2'd2) begin
						deg_q <= 1'b0;
					end else begin
						ci_q  <= ci_q + 2'd1;
						rem_q <= (mag_next << (F + 1)) + ACC_W'(len_q);
						dsh_q <= ACC_W'(len_q) << (F + 1);
						q_q   <= '0;
						dj_q  <= JW'(F);
					end
				end else begin
					if (div_ge) begin
						rem_q <= rem_sub;
					end
					q_q   <= qf;
					dsh_q <= dsh_q >> 1;
					dj_q  <= dj_q - JW'(1);
				end
			end
			S_EMIT: begin
				if (!rq_full) begin
					for (int j = 0; j < 6; j++) begin
						nrm_q[j] <= nrm_q[j+3];
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && deg_q) |->
		(tan_q[0] == '0 && tan_q[1] == '0 && tan_q[2] == '0 && !hand_q))
		else $error("degenerate result with nonzero tangent");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && dj_q == '0) |-> (qf <= {1'b1, {F{1'b0}}}))
		else $error("tangent quotient above one");

	a_pop_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !tq_empty) |=> (state_q == S_RED && rret_q == S_DP))
		else $error("triangle popped without reduction");

endmodule

>>> design/triangle_tangent_frame.sv
// triangle_tangent_frame: top level, front, triangle queue, back, result queue.
// Depends on ttf_pkg, ttf_fifo, ttf_front and ttf_back.
//
//  channel   handshake          payload
//  corner    push / full        pos_x pos_y pos_z tex_s tex_t norm_x norm_y norm_z
//  result    pop / empty        tangent_x tangent_y tangent_z handed_negative
//                               degenerate last_of_triangle
//
// First and second corners are never held off; the third is taken as soon as the
// triangle queue has room. The back works once per triangle on reductions and
// products, then per corner through 4 product steps, reduction steps, 33 square
// root steps and 3 x (NORMAL_WIDTH-1) division steps on one shared iterative unit.
// Reset clears the corner count, both queues and the back's sequencer.
// A full result queue stalls only the back; the front keeps taking corners until the triangle queue fills.
module triangle_tangent_frame #(
	parameter int COORD_WIDTH  = ttf_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_WIDTH = ttf_pkg::NORMAL_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [COORD_WIDTH-1:0]  pos_x,
	input  logic signed [COORD_WIDTH-1:0]  pos_y,
	input  logic signed [COORD_WIDTH-1:0]  pos_z,
	input  logic signed [COORD_WIDTH-1:0]  tex_s,
	input  logic signed [COORD_WIDTH-1:0]  tex_t,
	input  logic signed [NORMAL_WIDTH-1:0] norm_x,
	input  logic signed [NORMAL_WIDTH-1:0] norm_y,
	input  logic signed [NORMAL_WIDTH-1:0] norm_z,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [NORMAL_WIDTH-1:0] tangent_x,
	output logic signed [NORMAL_WIDTH-1:0] tangent_y,
	output logic signed [NORMAL_WIDTH-1:0] tangent_z,
	output logic                           handed_negative,
	output logic                           degenerate,
	output logic                           last_of_triangle
);
	import ttf_pkg::*;

	localparam int TW = 10 * (COORD_WIDTH + 1) + 9 * NORMAL_WIDTH;
	localparam int RW = 3 * NORMAL_WIDTH + 3;

	logic          tq_push, tq_full, tq_pop, tq_empty;
	logic [TW-1:0] tq_in, tq_out;
	logic          rq_push, rq_full;
	logic [RW-1:0] rq_in, rq_out;

	ttf_front #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_WIDTH(NORMAL_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_s(tex_s), .tex_t(tex_t),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.tq_push(tq_push), .tq_data(tq_in), .tq_full(tq_full)
	);

	ttf_fifo #(.W(TW), .DEPTH(TRI_QUEUE_DEPTH)) u_tri_queue (
		.clk(clk), .arst_n(arst_n), .push(tq_push), .data_in(tq_in), .full(tq_full),
		.pop(tq_pop), .data_out(tq_out), .empty(tq_empty)
	);

	ttf_back #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_WIDTH(NORMAL_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .tq_data(tq_out), .tq_empty(tq_empty),
		.tq_pop(tq_pop), .rq_push(rq_push), .rq_data(rq_in), .rq_full(rq_full)
	);

	ttf_fifo #(.W(RW), .DEPTH(RES_QUEUE_DEPTH)) u_res_queue (
		.clk(clk), .arst_n(arst_n), .push(rq_push), .data_in(rq_in), .full(rq_full),
		.pop(pop), .data_out(rq_out), .empty(empty)
	);

	assign tangent_x        = rq_out[3 + 2*NORMAL_WIDTH +: NORMAL_WIDTH];
	assign tangent_y        = rq_out[3 + NORMAL_WIDTH +: NORMAL_WIDTH];
	assign tangent_z        = rq_out[3 +: NORMAL_WIDTH];
	assign handed_negative  = rq_out[2];
	assign degenerate       = rq_out[1];
	assign last_of_triangle = rq_out[0];

endmodule

>>> verif/tb_triangle_tangent_frame.sv
// tb_triangle_tangent_frame: self-checking testbench for the triangle tangent frame block.
// Drives corners, predicts each tangent result in fixed point, compares results in order.
// Depends on ttf_pkg and triangle_tangent_frame.
module tb_triangle_tangent_frame;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = ttf_pkg::COORD_WIDTH_DEF;
	localparam int NW = ttf_pkg::NORMAL_WIDTH_DEF;
	localparam int FB = NW - 2;
	localparam int SDIR_W = 60 - 2 * NW;

	typedef struct packed {
		logic signed [CW-1:0] px, py, pz, ts, tt;
		logic signed [NW-1:0] nx, ny, nz;
	} corner_t;

	typedef struct packed {
		logic signed [NW-1:0] tx, ty, tz;
		logic hand, degen, last;
	} tangent_t;

	logic clk = 1'b0, arst_n = 1'b0, push = 1'b0, pop = 1'b0;
	logic full, empty;
	corner_t cur = '0;
	tangent_t got;

	corner_t pending_corners[$];
	tangent_t expected_tangents[$];
	corner_t held[2];
	int corner_idx = 0;
	int errors = 0, results_seen = 0, tris_sent = 0;
	int burst_left = 0, gap_left = 0, stall_phase = 0;
	logic taken = 1'b0;
	logic stim_done = 1'b0;

	triangle_tangent_frame i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz), .tex_s(cur.ts), .tex_t(cur.tt),
		.norm_x(cur.nx), .norm_y(cur.ny), .norm_z(cur.nz),
		.empty(empty), .pop(pop),
		.tangent_x(got.tx), .tangent_y(got.ty), .tangent_z(got.tz),
		.handed_negative(got.hand), .degenerate(got.degen), .last_of_triangle(got.last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void shrink(inout longint v[], input int bits);
		longint unsigned mx;
		longint unsigned m;
		int sh;
		mx = 0;
		sh = 0;
		foreach (v[i]) begin
			m = v[i] < 0 ? -v[i] : v[i];
			if (m > mx) mx = m;
		end
		while (sh < 63 && (mx >> sh) >= (64'd1 << bits)) sh++;
		foreach (v[i]) begin
			m = v[i] < 0 ? -v[i] : v[i];
			m = m >> sh;
			v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic tangent_t corner_tangent(longint n[3], longint b[], longint c[],
		bit neg, bit last);
		tangent_t r;
		longint bt[3];
		longint u[];
		longint d, trip;
		longint unsigned s, len, mag, q;
		logic signed [NW-1:0] comp[3];
		u = new[3];
		d = 0;
		s = 0;
		r = '0;
		r.last = last;
		for (int i = 0; i < 3; i++) bt[i] = neg ? -b[i] : b[i];
		for (int i = 0; i < 3; i++) d += n[i] * bt[i];
		for (int i = 0; i < 3; i++) u[i] = bt[i] * (64'sd1 <<< (2 * FB)) - n[i] * d;
		shrink(u, 30);
		for (int i = 0; i < 3; i++) s += u[i] * u[i];
		len = int_sqrt(s);
		if (len == 0) begin
			r.degen = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			mag = u[i] < 0 ? -u[i] : u[i];
			q = ((mag << (FB + 1)) + len) / (2 * len);
			comp[i] = NW'(u[i] < 0 ? -longint'(q) : longint'(q));
		end
		r.tx = comp[0];
		r.ty = comp[1];
		r.tz = comp[2];
		trip = (n[1] * b[2] - n[2] * b[1]) * c[0] + (n[2] * b[0] - n[0] * b[2]) * c[1]
			+ (n[0] * b[1] - n[1] * b[0]) * c[2];
		r.hand = trip < 0;
		return r;
	endfunction

	task automatic predict_corner(corner_t k);
		longint dp[], dt[], a[], c[];
		longint det;
		longint n[3];
		corner_t v[3];
		tangent_t r;
		if (corner_idx < 2) begin
			held[corner_idx] = k;
			corner_idx++;
			return;
		end
		corner_idx = 0;
		v[0] = held[0];
		v[1] = held[1];
		v[2] = k;
		dp = new[6];
		dt = new[4];
		a = new[3];
		c = new[3];
		dp[0] = longint'(v[1].px) - v[0].px;
		dp[1] = longint'(v[1].py) - v[0].py;
		dp[2] = longint'(v[1].pz) - v[0].pz;
		dp[3] = longint'(v[2].px) - v[0].px;
		dp[4] = longint'(v[2].py) - v[0].py;
		dp[5] = longint'(v[2].pz) - v[0].pz;
		dt[0] = longint'(v[1].ts) - v[0].ts;
		dt[1] = longint'(v[1].tt) - v[0].tt;
		dt[2] = longint'(v[2].ts) - v[0].ts;
		dt[3] = longint'(v[2].tt) - v[0].tt;
		shrink(dp, 31);
		shrink(dt, 31);
		det = dt[0] * dt[3] - dt[2] * dt[1];
		for (int i = 0; i < 3; i++) begin
			a[i] = dt[3] * dp[i] - dt[1] * dp[3 + i];
			c[i] = dt[0] * dp[3 + i] - dt[2] * dp[i];
		end
		shrink(a, SDIR_W);
		shrink(c, NW);
		for (int j = 0; j < 3; j++) begin
			n[0] = longint'(v[j].nx);
			n[1] = longint'(v[j].ny);
			n[2] = longint'(v[j].nz);
			if (det == 0) begin
				r = '0;
				r.degen = 1'b1;
				r.last = (j == 2);
			end else r = corner_tangent(n, a, c, det < 0, j == 2);
			expected_tangents.push_back(r);
		end
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 'h40000)) - 'sh20000;
			default: return $signed($urandom_range(0, 64)) - 32;
		endcase
	endfunction

	function automatic corner_t rnd_corner(int mode);
		corner_t k;
		k.px = rnd_coord(mode);
		k.py = rnd_coord(mode);
		k.pz = rnd_coord(mode);
		k.ts = rnd_coord(mode);
		k.tt = rnd_coord(mode);
		if ($urandom_range(0, 3) == 0) begin
			k.nx = NW'($urandom);
			k.ny = NW'($urandom);
			k.nz = NW'($urandom);
		end else begin
			k.nx = NW'($signed($urandom_range(0, 32768)) - 16384);
			k.ny = NW'($signed($urandom_range(0, 32768)) - 16384);
			k.nz = NW'($signed($urandom_range(0, 32768)) - 16384);
		end
		return k;
	endfunction

	function automatic corner_t mk(int x, int y, int z, int s, int t, int nx, int ny, int nz);
		corner_t k;
		k.px = x;
		k.py = y;
		k.pz = z;
		k.ts = s;
		k.tt = t;
		k.nx = NW'(nx);
		k.ny = NW'(ny);
		k.nz = NW'(nz);
		return k;
	endfunction

	// sender: bursts and gaps, inputs change on the falling edge
	always @(posedge clk) taken <= push && !full;

	always @(negedge clk) begin
		if (arst_n && (!push || taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				push <= 1'b0;
			end else if (pending_corners.size() != 0) begin
				cur <= pending_corners.pop_front();
				push <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else burst_left <= burst_left - 1;
			end else push <= 1'b0;
		end
	end

	always @(posedge clk) if (push && !full) predict_corner(cur);

	// receiver: stall pattern that shifts between phases
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 500) % 3)
			0: pop <= 1'b1;
			1: pop <= $urandom_range(0, 3) != 0;
			default: pop <= (stall_phase % 97) < 20 ? 1'b0 : $urandom_range(0, 1);
		endcase
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			results_seen++;
			if (expected_tangents.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %p", $time, got);
			end else begin
				tangent_t e;
				e = expected_tangents.pop_front();
				if (got.tx !== e.tx || got.ty !== e.ty || got.tz !== e.tz
					|| got.hand !== e.hand || got.degen !== e.degen || got.last !== e.last) begin
					errors++;
					$display("%0t: mismatch, expected %p, actual %p", $time, e, got);
				end
			end
		end
	end

	initial begin
		int one;
		one = 1 << FB;
		// extremes of every field
		pending_corners.push_back(mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 0,
			16'h7fff, 16'h8000, 0));
		pending_corners.push_back(mk(32'h80000000, 32'h7fffffff, -1, 32'h7fffffff,
			32'h80000000, 16'h8000, 16'h7fff, -1));
		pending_corners.push_back(mk(-1, 0, 32'h7fffffff, 0, 32'h7fffffff,
			0, 0, 16'h7fff));
		// unit right triangle, normal +z
		pending_corners.push_back(mk(0, 0, 0, 0, 0, 0, 0, one));
		pending_corners.push_back(mk(65536, 0, 0, 65536, 0, 0, 0, one));
		pending_corners.push_back(mk(0, 65536, 0, 0, 65536, 0, 0, one));
		// mirrored texture, negative determinant
		pending_corners.push_back(mk(0, 0, 0, 0, 0, 0, 0, one));
		pending_corners.push_back(mk(65536, 0, 0, -65536, 0, 0, 0, one));
		pending_corners.push_back(mk(0, 65536, 0, 0, 65536, 0, 0, one));
		// zero determinant: identical texture coordinates
		pending_corners.push_back(mk(0, 0, 0, 100, 100, 0, 0, one));
		pending_corners.push_back(mk(65536, 0, 0, 100, 100, 0, 0, one));
		pending_corners.push_back(mk(0, 65536, 0, 100, 100, 0, 0, one));
		// zero length: first two normals along the s direction
		pending_corners.push_back(mk(0, 0, 0, 0, 0, one, 0, 0));
		pending_corners.push_back(mk(65536, 0, 0, 65536, 0, one, 0, 0));
		pending_corners.push_back(mk(0, 65536, 0, 0, 65536, 0, 0, one));
		// all-zero corners
		repeat (3) pending_corners.push_back('0);
		repeat (62) begin
			int mode;
			corner_t k;
			mode = $urandom_range(0, 2);
			for (int j = 0; j < 3; j++) begin
				k = rnd_corner(mode);
				if (j > 0 && $urandom_range(0, 15) == 0) begin
					k.ts = pending_corners[$].ts;
					k.tt = pending_corners[$].tt;
				end
				pending_corners.push_back(k);
			end
		end
		tris_sent = pending_corners.size() / 3;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_corners.size() == 0 && !push);
		wait (expected_tangents.size() == 0);
		repeat (400) @(posedge clk);
		$display("Covered %0d triangles, %0d tangent results checked", tris_sent,
			results_seen);
		if (errors == 0 && expected_tangents.size() == 0)
			$display("[triangle_tangent_frame] OK");
		else
			$display("[triangle_tangent_frame] ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("Timed out with %0d results outstanding", expected_tangents.size());
		$display("[triangle_tangent_frame] ERROR");
		$finish;
	end
endmodule
